// ----- design/mbe_pkg.sv -----
// Shared types, constants and helpers for the escape-time block.
`default_nettype none
package mbe_pkg;

    // Field and datapath widths
    localparam int PIX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int ITER_W    = 16;
    localparam int Q_W       = 32;
    localparam int EXT_W     = 31;
    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;
    localparam int DIVD_W    = PIX_W + EXT_W;
    localparam int DSR_W     = 12;
    localparam int DIV_CNT_W = 6;
    localparam int SUM_W     = DIVD_W + 2;
    localparam int PROD_W    = 2 * Q_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // |z|^2 escape bound: 4.0 in the squared fixed-point scale
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PIX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_RE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IM  = 3'd6;

    // Register reset values
    localparam logic [ITER_W-1:0]     RST_MAX_ITER   = 16'd256;
    localparam logic [CNT_W-1:0]      RST_WIDTH_PIX  = 13'd1024;
    localparam logic [CNT_W-1:0]      RST_HEIGHT_PIX = 13'd512;
    localparam logic signed [Q_W-1:0] RST_MIN        = -32'sd536870912;
    localparam logic [EXT_W-1:0]      RST_EXTENT     = 31'd1073741824;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [ITER_W-1:0] escape_count;
        logic              escaped;
    } result_t;

    typedef struct packed {
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
    } point_t;

    typedef struct packed {
        logic [ITER_W-1:0]     max_iterations;
        logic [CNT_W-1:0]      width_pixels;
        logic [CNT_W-1:0]      height_pixels;
        logic signed [Q_W-1:0] plane_min_re;
        logic signed [Q_W-1:0] plane_min_im;
        logic [EXT_W-1:0]      plane_width_re;
        logic [EXT_W-1:0]      plane_height_im;
    } cfg_t;

    // Clamp a wide signed sum to the Q4.28 range
    function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
        logic [SUM_W-Q_W:0] top;
        top = v[SUM_W-1:Q_W-1];
        if (top == '0 || top == '1) begin
            return v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/mbe_div.sv -----
// Restoring divider, one quotient bit per cycle, for the pixel-to-plane mapping.
`default_nettype none
module mbe_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [mbe_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [mbe_pkg::DSR_W-1:0]    divisor,
    output logic                              busy,
    output logic [mbe_pkg::DIVD_W-1:0]        quotient
);

    logic                           busy_reg, busy_next;
    logic [mbe_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mbe_pkg::DSR_W-1:0]      rem_reg, rem_next;
    logic [mbe_pkg::DSR_W-1:0]      dsr_reg, dsr_next;
    logic [mbe_pkg::DIVD_W-1:0]     quo_reg, quo_next;
    logic [mbe_pkg::DSR_W:0]        trial;

    assign trial = {rem_reg, quo_reg[mbe_pkg::DIVD_W-1]};

    // Load the operands on start; else shift in the next dividend bit, subtract when it fits
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = mbe_pkg::DIV_CNT_W'(mbe_pkg::DIVD_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = mbe_pkg::DSR_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[mbe_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[mbe_pkg::DSR_W-1:0];
                quo_next = {quo_reg[mbe_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mbe_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- design/mbe_front.sv -----
// Front end: takes a pixel beat and maps it to a point c of the plane.
`default_nettype none
module mbe_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mbe_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mbe_pkg::pixel_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mbe_pkg::point_t       out_data
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_START = 4'b0010,
        F_WAIT  = 4'b0100,
        F_PUSH  = 4'b1000
    } front_state_t;

    front_state_t                state_reg, state_next;
    mbe_pkg::pixel_t             pix_reg, pix_next;
    logic                        div_start;
    logic                        busy_x, busy_y;
    logic [mbe_pkg::DIVD_W-1:0]  quo_x, quo_y;
    logic [mbe_pkg::DIVD_W-1:0]  prod_x, prod_y;
    logic [mbe_pkg::SUM_W-1:0]   sum_re, sum_im;

    // Divisor is the clamped pixel count minus one
    function automatic logic [mbe_pkg::DSR_W-1:0] span(input logic [mbe_pkg::CNT_W-1:0] n);
        logic [mbe_pkg::CNT_W-1:0] m;
        m = n - 1'b1;
        if (n > mbe_pkg::CNT_W'(mbe_pkg::MAX_DIM)) begin
            return mbe_pkg::DSR_W'(mbe_pkg::MAX_DIM - 1);
        end
        return m[mbe_pkg::DSR_W-1:0];
    endfunction

    assign div_start = (state_reg == F_START);
    assign prod_x = mbe_pkg::DIVD_W'(pix_reg.pixel_x) * mbe_pkg::DIVD_W'(cfg.plane_width_re);
    assign prod_y = mbe_pkg::DIVD_W'(pix_reg.pixel_y) * mbe_pkg::DIVD_W'(cfg.plane_height_im);

    mbe_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (span(cfg.width_pixels)),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    mbe_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (span(cfg.height_pixels)),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // Window start plus offset, saturated; counts below two pin to the start
    assign sum_re = mbe_pkg::SUM_W'(cfg.plane_min_re) + {2'b00, quo_x};
    assign sum_im = mbe_pkg::SUM_W'(cfg.plane_min_im) + {2'b00, quo_y};

    always_comb begin
        out_data.c_re = $signed(mbe_pkg::sat_q(sum_re));
        out_data.c_im = $signed(mbe_pkg::sat_q(sum_im));
        if (cfg.width_pixels < mbe_pkg::CNT_W'(2)) begin
            out_data.c_re = cfg.plane_min_re;
        end
        if (cfg.height_pixels < mbe_pkg::CNT_W'(2)) begin
            out_data.c_im = cfg.plane_min_im;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        pix_next   = pix_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    pix_next   = in_data;
                    state_next = F_START;
                end
            end
            F_START: begin
                state_next = F_WAIT;
            end
            F_WAIT: begin
                if (!busy_x && !busy_y) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (out_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pix_reg <= pix_next;
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);

endmodule
`default_nettype wire

// ----- design/mbe_fifo.sv -----
// Two-entry queue of mapped points between front and back end.
`default_nettype none
module mbe_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mbe_pkg::point_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mbe_pkg::point_t       out_data
);

    mbe_pkg::point_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ----- design/mbe_core.sv -----
// Back end: iterates z = z^2 + c and reports the escape step.
`default_nettype none
module mbe_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [mbe_pkg::ITER_W-1:0]  max_iterations,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire mbe_pkg::point_t             in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output mbe_pkg::result_t                 out_data
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MUL  = 4'b0010,
        C_UPD  = 4'b0100,
        C_FIN  = 4'b1000
    } core_state_t;

    core_state_t                         state_reg, state_next;
    mbe_pkg::point_t                     c_reg, c_next;
    mbe_pkg::point_t                     z_reg, z_next;
    logic [mbe_pkg::ITER_W-1:0]          iter_reg, iter_next;
    logic [mbe_pkg::ITER_W-1:0]          iter_inc;
    logic signed [mbe_pkg::PROD_W-1:0]   re2_reg, im2_reg, prod_reg;
    logic signed [mbe_pkg::PROD_W-1:0]   re2, im2, prod;
    logic signed [mbe_pkg::PROD_W-1:0]   diff;
    logic [mbe_pkg::PROD_W-1:0]          mag;
    logic [mbe_pkg::SUM_W-1:0]           sum_re, sum_im;
    mbe_pkg::result_t                    res_reg, res_next;
    logic                                out_valid_reg, out_valid_next;
    mbe_pkg::result_t                    out_reg, out_next;
    logic                                slot_free;

    // Squares and cross product of z, registered
    assign re2  = z_reg.c_re * z_reg.c_re;
    assign im2  = z_reg.c_im * z_reg.c_im;
    assign prod = z_reg.c_re * z_reg.c_im;

    // Escape test and next z from the registered products
    assign mag    = $unsigned(re2_reg) + $unsigned(im2_reg);
    assign diff   = re2_reg - im2_reg;
    assign sum_re = mbe_pkg::SUM_W'($signed(diff[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_BITS]))
                  + mbe_pkg::SUM_W'(c_reg.c_re);
    assign sum_im = mbe_pkg::SUM_W'($signed(prod_reg[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_BITS-1]))
                  + mbe_pkg::SUM_W'(c_reg.c_im);
    assign iter_inc  = iter_reg + 1'b1;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        c_next         = c_reg;
        z_next         = z_reg;
        iter_next      = iter_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        case (state_reg)
            C_IDLE: begin
                if (in_valid) begin
                    c_next    = in_data;
                    z_next    = in_data;
                    iter_next = '0;
                    res_next  = '0;
                    if (max_iterations == '0) begin
                        state_next = C_FIN;
                    end else begin
                        state_next = C_MUL;
                    end
                end
            end
            C_MUL: begin
                state_next = C_UPD;
            end
            C_UPD: begin
                if (mag > mbe_pkg::ESC_LIMIT) begin
                    res_next.escape_count = iter_reg;
                    res_next.escaped      = 1'b1;
                    state_next            = C_FIN;
                end else begin
                    z_next.c_re = $signed(mbe_pkg::sat_q(sum_re));
                    z_next.c_im = $signed(mbe_pkg::sat_q(sum_im));
                    iter_next   = iter_inc;
                    if (iter_inc == max_iterations) begin
                        state_next = C_FIN;
                    end else begin
                        state_next = C_MUL;
                    end
                end
            end
            C_FIN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        c_reg    <= c_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        re2_reg  <= re2;
        im2_reg  <= im2;
        prod_reg <= prod;
    end

    assign in_ready  = (state_reg == C_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ----- design/mandelbrot_escape_time.sv -----
// Top level of the Mandelbrot escape-time block.
//
// Usage: pixel beats (pixel_x, pixel_y) enter on s_valid/s_ready; one result
// beat (escape_count, escaped) per pixel leaves on m_valid/m_ready, in order.
// The window and iteration limit are set through cfg_we/cfg_addr/cfg_wdata,
// register index as listed: 0 limit, 1 columns, 2 rows, 3/4 window start,
// 5/6 window extent; write them only while the block is idle.
// Flow: the front end maps a pixel through the bit-serial divider (43
// quotient bits) and takes a new pixel only once its mapped point has been
// passed on. The back end runs each iteration as a multiply stage, then
// escape test and update, with a setup state before and a hand-off state
// after; it takes a new point only once the last result is handed off.
// A two-entry queue between the ends lets mapping of later pixels overlap
// the iteration of the current one.
// Reset (aresetn low, synchronous) empties the queue and restores the
// register defaults. If m_ready stays low, the finished result is held in
// the output register; the back end takes one more point and then waits,
// the queue fills, the front end holds one more mapped point and s_ready stays low.
`default_nettype none
module mandelbrot_escape_time (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [mbe_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mbe_pkg::pixel_t                 s_pixel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mbe_pkg::result_t                     m_result
);

    mbe_pkg::cfg_t   cfg_reg, cfg_next;
    logic            fr_valid, fr_ready;
    mbe_pkg::point_t fr_data;
    logic            q_valid, q_ready;
    mbe_pkg::point_t q_data;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                mbe_pkg::REG_MAX_ITER:   cfg_next.max_iterations  = cfg_wdata[15:0];
                mbe_pkg::REG_WIDTH_PIX:  cfg_next.width_pixels    = cfg_wdata[12:0];
                mbe_pkg::REG_HEIGHT_PIX: cfg_next.height_pixels   = cfg_wdata[12:0];
                mbe_pkg::REG_MIN_RE:     cfg_next.plane_min_re    = $signed(cfg_wdata);
                mbe_pkg::REG_MIN_IM:     cfg_next.plane_min_im    = $signed(cfg_wdata);
                mbe_pkg::REG_WIDTH_RE:   cfg_next.plane_width_re  = cfg_wdata[30:0];
                mbe_pkg::REG_HEIGHT_IM:  cfg_next.plane_height_im = cfg_wdata[30:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_iterations  <= mbe_pkg::RST_MAX_ITER;
            cfg_reg.width_pixels    <= mbe_pkg::RST_WIDTH_PIX;
            cfg_reg.height_pixels   <= mbe_pkg::RST_HEIGHT_PIX;
            cfg_reg.plane_min_re    <= mbe_pkg::RST_MIN;
            cfg_reg.plane_min_im    <= mbe_pkg::RST_MIN;
            cfg_reg.plane_width_re  <= mbe_pkg::RST_EXTENT;
            cfg_reg.plane_height_im <= mbe_pkg::RST_EXTENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mbe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_pixel),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    mbe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    mbe_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_iterations (cfg_reg.max_iterations),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_data        (q_data),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_data       (m_result)
    );

endmodule
`default_nettype wire

// ----- sim/tb_mandelbrot_escape_time.sv -----
// Testbench for the Mandelbrot escape-time block: directed corners plus random windows.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int MISMATCH_SHOW  = 10;
    localparam int RAND_PHASES    = 11;
    localparam int PHASE_PIXELS   = 100;

    // Index past the last register, writes there must change nothing
    localparam logic [mbe_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam longint          Q_HI      = 64'sd2147483647;
    localparam longint          Q_LO      = -64'sd2147483648;
    localparam longint unsigned MAG_BOUND = 64'd1 << (2 * mbe_pkg::FRAC_BITS + 2);

    // Handy Q4.28 values
    localparam logic [31:0] Q_NEG_TWO  = 32'hE000_0000;
    localparam logic [31:0] Q_NEG_HALF = 32'hF800_0000;
    localparam logic [31:0] Q_FOUR     = 32'h4000_0000;
    localparam logic [31:0] Q_ZERO     = 32'h0000_0000;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [mbe_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [mbe_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    mbe_pkg::pixel_t               s_pixel   = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    mbe_pkg::result_t              m_result;

    // Shadow copy of the block's registers
    logic [mbe_pkg::ITER_W-1:0]     lim_iter    = mbe_pkg::RST_MAX_ITER;
    logic [mbe_pkg::CNT_W-1:0]      n_cols      = mbe_pkg::RST_WIDTH_PIX;
    logic [mbe_pkg::CNT_W-1:0]      n_rows      = mbe_pkg::RST_HEIGHT_PIX;
    logic signed [mbe_pkg::Q_W-1:0] win_re0     = mbe_pkg::RST_MIN;
    logic signed [mbe_pkg::Q_W-1:0] win_im0     = mbe_pkg::RST_MIN;
    logic [mbe_pkg::EXT_W-1:0]      win_re_span = mbe_pkg::RST_EXTENT;
    logic [mbe_pkg::EXT_W-1:0]      win_im_span = mbe_pkg::RST_EXTENT;

    mbe_pkg::result_t pending_escapes[$];
    mbe_pkg::result_t want;
    int               mismatches   = 0;
    int               results_seen = 0;
    int               idle_cycles  = 0;
    int               rx_hold      = 0;
    bit               tx_quiet     = 1'b0;
    bit               rx_quiet     = 1'b0;

    mandelbrot_escape_time u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [mbe_pkg::Q_W-1:0] clamp_q(input longint v);
        if (v > Q_HI) begin
            return Q_HI[31:0];
        end else if (v < Q_LO) begin
            return Q_LO[31:0];
        end
        return v[31:0];
    endfunction

    // Pixel index to plane coordinate, truncated quotient, then clamped
    function automatic logic signed [mbe_pkg::Q_W-1:0] map_coord(
            input logic [mbe_pkg::PIX_W-1:0]     pix,
            input logic [mbe_pkg::CNT_W-1:0]     count,
            input logic signed [mbe_pkg::Q_W-1:0] start,
            input logic [mbe_pkg::EXT_W-1:0]     extent);
        longint unsigned num, den, cnt;
        cnt = 64'(count);
        if (cnt > 64'(mbe_pkg::MAX_DIM)) cnt = 64'(mbe_pkg::MAX_DIM);
        if (cnt < 64'd2) return start;
        num = 64'(pix) * 64'(extent);
        den = cnt - 64'd1;
        return clamp_q(longint'(start) + longint'(num / den));
    endfunction

    function automatic mbe_pkg::result_t predict_escape(input mbe_pkg::pixel_t p);
        logic signed [mbe_pkg::Q_W-1:0] c_re, c_im, z_re, z_im;
        longint                         re, im, re2, im2, diff, prod;
        longint unsigned                mag;
        int unsigned                    step;
        mbe_pkg::result_t               r;
        r = '0;
        c_re = map_coord(p.pixel_x, n_cols, win_re0, win_re_span);
        c_im = map_coord(p.pixel_y, n_rows, win_im0, win_im_span);
        z_re = c_re;
        z_im = c_im;
        for (step = 0; step < lim_iter; step++) begin
            re   = z_re;
            im   = z_im;
            re2  = re * re;
            im2  = im * im;
            mag  = re2 + im2;
            if (mag > MAG_BOUND) begin
                r.escape_count = step[mbe_pkg::ITER_W-1:0];
                r.escaped      = 1'b1;
                return r;
            end
            diff = re2 - im2;
            prod = re * im;
            // Arithmetic shift floors; the doubled product uses one bit less
            z_re = clamp_q((diff >>> mbe_pkg::FRAC_BITS) + longint'(c_re));
            z_im = clamp_q((prod >>> (mbe_pkg::FRAC_BITS - 1)) + longint'(c_im));
        end
        return r;
    endfunction

    function automatic void apply_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [mbe_pkg::CFG_DAT_W-1:0] data);
        case (idx)
            mbe_pkg::REG_MAX_ITER:   lim_iter    = data[mbe_pkg::ITER_W-1:0];
            mbe_pkg::REG_WIDTH_PIX:  n_cols      = data[mbe_pkg::CNT_W-1:0];
            mbe_pkg::REG_HEIGHT_PIX: n_rows      = data[mbe_pkg::CNT_W-1:0];
            mbe_pkg::REG_MIN_RE:     win_re0     = data[mbe_pkg::Q_W-1:0];
            mbe_pkg::REG_MIN_IM:     win_im0     = data[mbe_pkg::Q_W-1:0];
            mbe_pkg::REG_WIDTH_RE:   win_re_span = data[mbe_pkg::EXT_W-1:0];
            mbe_pkg::REG_HEIGHT_IM:  win_im_span = data[mbe_pkg::EXT_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- random helpers

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Keep the low w bits of v, fill the rest with noise
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] mask;
        mask = (32'd1 << w) - 32'd1;
        return ($urandom & ~mask) | (v & mask);
    endfunction

    function automatic logic [31:0] rand_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 40);
        if (r < 96) return $urandom_range(41, 300);
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [31:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(2, 64);
        if (r < 85) return $urandom_range(0, 8191);
        return $urandom_range(4096, 8191);
    endfunction

    // Start near the interesting part of the plane, sometimes anywhere
    function automatic logic [31:0] rand_start();
        if ($urandom_range(0, 3) != 0) return 32'hD800_0000 + $urandom_range(0, 939524096);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_span();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, 1073741824);
        return $urandom;
    endfunction

    function automatic logic [mbe_pkg::PIX_W-1:0] rand_coord(
            input logic [mbe_pkg::CNT_W-1:0] count);
        int lim;
        if (count < 2 || $urandom_range(0, 4) == 0) begin
            return mbe_pkg::PIX_W'($urandom_range(0, 4095));
        end
        lim = (count > mbe_pkg::MAX_DIM) ? mbe_pkg::MAX_DIM : int'(count);
        return mbe_pkg::PIX_W'($urandom_range(0, lim - 1));
    endfunction

    // ---------------------------------------------------------------- drivers

    // Called on a falling edge; returns on the falling edge after the beat is taken
    task automatic send_pixel(input logic [mbe_pkg::PIX_W-1:0] px,
                              input logic [mbe_pkg::PIX_W-1:0] py);
        int gap;
        if (cfg_we) cfg_we <= 1'b0;
        gap = (tx_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= '{pixel_x: px, pixel_y: py};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbe_pkg::CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        apply_reg(idx, data);
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_escapes.size() != 0) @(negedge aclk);
    endtask

    task automatic write_window(input logic [31:0] re0, input logic [31:0] im0,
                                input logic [31:0] re_span, input logic [31:0] im_span);
        write_reg(mbe_pkg::REG_MIN_RE, re0);
        write_reg(mbe_pkg::REG_MIN_IM, im0);
        write_reg(mbe_pkg::REG_WIDTH_RE, re_span);
        write_reg(mbe_pkg::REG_HEIGHT_IM, im_span);
    endtask

    // Result side stalls
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 5) == 0) rx_hold <= pick_gap();
        end
    end

    // ---------------------------------------------------------------- monitors

    // Predict each accepted pixel
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_escapes.insert(pending_escapes.size(), predict_escape(s_pixel));
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_escapes.size() == 0) begin
                if (mismatches < MISMATCH_SHOW)
                    $display("result %0d unexpected: count=%0d escaped=%0b",
                             results_seen, m_result.escape_count, m_result.escaped);
                mismatches++;
            end else begin
                want = pending_escapes.pop_front();
                if (m_result.escape_count !== want.escape_count ||
                    m_result.escaped !== want.escaped) begin
                    if (mismatches < MISMATCH_SHOW)
                        $display("result %0d: count=%0d escaped=%0b, want count=%0d escaped=%0b",
                                 results_seen, m_result.escape_count, m_result.escaped,
                                 want.escape_count, want.escaped);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // Cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("mandelbrot_escape_time test failed");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Reset window: corners, a point near the origin, one more inside point, and a pixel far outside
    task automatic test_default_window();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1023, 12'd511);
        send_pixel(12'd512, 12'd256);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd300, 12'd100);
    endtask

    // Zero limit, a limit of one, and the largest limit
    task automatic test_iteration_limits();
        drain_results();
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd0);
        send_pixel(12'd512, 12'd256);
        drain_results();
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd512, 12'd256);
        drain_results();
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd65535);
        send_pixel(12'd512, 12'd256);
        send_pixel(12'd300, 12'd100);
    endtask

    // Pixel counts below two, at and above the maximum, clamped mapping
    task automatic test_pixel_counts();
        drain_results();
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd20);
        write_reg(mbe_pkg::REG_WIDTH_PIX, 32'd0);
        write_reg(mbe_pkg::REG_HEIGHT_PIX, 32'd1);
        write_window(Q_NEG_HALF, Q_ZERO, Q_FOUR, Q_FOUR);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd17, 12'd0);
        drain_results();
        write_reg(mbe_pkg::REG_WIDTH_PIX, 32'd8191);
        write_reg(mbe_pkg::REG_HEIGHT_PIX, 32'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd2048);
        send_pixel(12'd1170, 12'd4095);
        // Windows start at both ends of the Q4.28 range; mapping runs past the top
        drain_results();
        write_reg(mbe_pkg::REG_WIDTH_PIX, 32'd2);
        write_reg(mbe_pkg::REG_HEIGHT_PIX, 32'd16);
        write_window(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        drain_results();
        write_window(32'h8000_0000, 32'hF000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd15);
    endtask

    // Magnitude exactly two is not an escape: c = -2 stays bounded, c = 2 escapes once z grows past it
    task automatic test_escape_boundary();
        drain_results();
        write_reg(mbe_pkg::REG_MAX_ITER, 32'd20);
        write_reg(mbe_pkg::REG_WIDTH_PIX, 32'd2);
        write_reg(mbe_pkg::REG_HEIGHT_PIX, 32'd2);
        write_window(Q_NEG_TWO, Q_ZERO, Q_FOUR, Q_ZERO);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd1, 12'd1);
    endtask

    task automatic test_unused_register();
        drain_results();
        write_reg(REG_NONE, $urandom);
        send_pixel(12'd0, 12'd1);
    endtask

    task automatic test_random_windows();
        int phase, n;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            tx_quiet = (phase % 4 == 3);
            rx_quiet = (phase % 4 == 1);
            write_reg(mbe_pkg::REG_MAX_ITER, with_junk(rand_limit(), mbe_pkg::ITER_W));
            write_reg(mbe_pkg::REG_WIDTH_PIX, with_junk(rand_count(), mbe_pkg::CNT_W));
            write_reg(mbe_pkg::REG_HEIGHT_PIX, with_junk(rand_count(), mbe_pkg::CNT_W));
            write_window(rand_start(), rand_start(),
                         with_junk(rand_span(), mbe_pkg::EXT_W),
                         with_junk(rand_span(), mbe_pkg::EXT_W));
            for (n = 0; n < PHASE_PIXELS; n++) send_pixel(rand_coord(n_cols), rand_coord(n_rows));
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_default_window();
        test_iteration_limits();
        test_pixel_counts();
        test_escape_boundary();
        test_unused_register();
        test_random_windows();
        drain_results();
        repeat (100) @(negedge aclk);
        if (mismatches == 0 && pending_escapes.size() == 0) begin
            $display("mandelbrot_escape_time test passed");
        end else begin
            $display("mandelbrot_escape_time test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mbe_pkg.sv
design/mbe_div.sv
design/mbe_front.sv
design/mbe_fifo.sv
design/mbe_core.sv
design/mandelbrot_escape_time.sv
sim/tb_mandelbrot_escape_time.sv
